// ===== sv/fde_pkg.sv =====
package fde_pkg;

   localparam int DEPTH_BITS  = 17;
   localparam int DELAY_DEPTH = 1 << DEPTH_BITS;
   localparam int DELAY_MAX   = DELAY_DEPTH - 2;
   localparam int SAMPLE_BITS = 24;
   localparam int CTRL_BITS   = 17;
   localparam int Q_BITS      = 16;
   localparam int Q_ONE       = 1 << Q_BITS;
   localparam int SMOOTH_COEF = 13;
   localparam int SD_BITS     = DEPTH_BITS + Q_BITS;
   localparam int DIFF_W      = SD_BITS + 1;
   localparam int MUL_A_W     = SAMPLE_BITS + 1;
   localparam int MUL_B_W     = CTRL_BITS + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int STEP_BITS   = 4;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type S_IDLE       = 4'd0;
   localparam step_type S_DIFF       = 4'd1;
   localparam step_type S_SMOOTH_MUL = 4'd2;
   localparam step_type S_SMOOTH_ADD = 4'd3;
   localparam step_type S_TAP        = 4'd4;
   localparam step_type S_RD_A       = 4'd5;
   localparam step_type S_RD_B       = 4'd6;
   localparam step_type S_DAB        = 4'd7;
   localparam step_type S_INTERP_MUL = 4'd8;
   localparam step_type S_INTERP_ADD = 4'd9;
   localparam step_type S_FB_MUL     = 4'd10;
   localparam step_type S_WRITE      = 4'd11;
   localparam step_type S_DRY_MUL    = 4'd12;
   localparam step_type S_OUT        = 4'd13;

   typedef enum logic [1:0] {WT_NONE, WT_REQ, WT_RSP} wait_type;
   typedef enum logic [1:0] {MA_DAB, MA_R, MA_X} mul_a_type;
   typedef enum logic [1:0] {MB_FRAC, MB_FB, MB_MIX, MB_DRY} mul_b_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_D13, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {RD_NONE, RD_TAP_A, RD_TAP_B} rd_sel_type;

   typedef struct packed {
      wait_type   wait_sel;
      step_type   nxt;
      logic       lat_in;
      logic       ld_diff;
      logic       ld_sd;
      logic       ld_df;
      rd_sel_type rd_sel;
      logic       ld_a;
      logic       ld_dab;
      logic       ld_r;
      logic       wr_mem;
      logic       ld_out;
      acc_op_type acc_op;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type cw;
      logic          go;
   } seq_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_busy;
   } dp_status_type;

   typedef struct packed {
      logic                   wr_en;
      logic [DEPTH_BITS-1:0]  wr_addr;
      logic [SAMPLE_BITS-1:0] wr_data;
      logic [DEPTH_BITS-1:0]  rd_addr;
   } ram_req_type;

   function automatic ctrl_word_type ucode_rom(input step_type s);
      ctrl_word_type cw;
      cw = '0;
      cw.nxt = step_type'(s + 1'b1);
      case (s)
         S_IDLE: begin
            cw.wait_sel = WT_REQ;
            cw.lat_in   = 1'b1;
         end
         S_DIFF:       cw.ld_diff = 1'b1;
         S_SMOOTH_MUL: cw.acc_op  = ACC_D13;
         S_SMOOTH_ADD: cw.ld_sd   = 1'b1;
         S_TAP:        cw.ld_df   = 1'b1;
         S_RD_A:       cw.rd_sel  = RD_TAP_A;
         S_RD_B: begin
            cw.rd_sel = RD_TAP_B;
            cw.ld_a   = 1'b1;
         end
         S_DAB:        cw.ld_dab  = 1'b1;
         S_INTERP_MUL: begin
            cw.acc_op = ACC_LOAD;
            cw.mul_a  = MA_DAB;
            cw.mul_b  = MB_FRAC;
         end
         S_INTERP_ADD: cw.ld_r    = 1'b1;
         S_FB_MUL: begin
            cw.acc_op = ACC_LOAD;
            cw.mul_a  = MA_R;
            cw.mul_b  = MB_FB;
         end
         S_WRITE: begin
            cw.wr_mem = 1'b1;
            cw.acc_op = ACC_LOAD;
            cw.mul_a  = MA_R;
            cw.mul_b  = MB_MIX;
         end
         S_DRY_MUL: begin
            cw.acc_op = ACC_ADD;
            cw.mul_a  = MA_X;
            cw.mul_b  = MB_DRY;
         end
         S_OUT: begin
            cw.wait_sel = WT_RSP;
            cw.ld_out   = 1'b1;
            cw.nxt      = S_IDLE;
         end
         default: cw.nxt = S_IDLE;
      endcase
      return cw;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] r;
      hi = $signed({{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ===== sv/fde_ifs.sv =====
interface fde_req_if import fde_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_in;
   logic        [CTRL_BITS-1:0]   delay_target;
   logic        [CTRL_BITS-1:0]   feedback_gain;
   logic        [CTRL_BITS-1:0]   mix_level;
   logic                          bypass_on;

   modport source (output valid, audio_in, delay_target, feedback_gain, mix_level,
                   bypass_on, input ready);
   modport sink   (input valid, audio_in, delay_target, feedback_gain, mix_level,
                   bypass_on, output ready);
endinterface

interface fde_rsp_if import fde_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_out;

   modport source (output valid, audio_out, input ready);
   modport sink   (input valid, audio_out, output ready);
endinterface

// ===== sv/fde_ram.sv =====
module fde_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fde_useq.sv =====
module fde_useq import fde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output seq_ctrl_type  ctrl
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw;
   logic          go;

   always_comb begin
      cw = ucode_rom(step_ff);
      case (cw.wait_sel)
         WT_NONE: go = 1'b1;
         WT_REQ:  go = status.req_valid;
         WT_RSP:  go = !status.rsp_busy;
         default: go = 1'b1;
      endcase
      step_in = go ? cw.nxt : step_ff;
      ctrl.cw = cw;
      ctrl.go = go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== sv/fde_datapath.sv =====
module fde_datapath import fde_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  seq_ctrl_type           ctrl,
   output dp_status_type          status,
   output ram_req_type            ram_req,
   input  logic [SAMPLE_BITS-1:0] ram_rd_data,
   fde_req_if.sink                req_chan,
   fde_rsp_if.source              rsp_chan
);

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic        [DEPTH_BITS-1:0]  tgt_ff, tgt_in;
   logic        [CTRL_BITS-1:0]   fb_ff, fb_in;
   logic        [CTRL_BITS-1:0]   mix_ff, mix_in;
   logic                          byp_ff, byp_in;
   logic signed [DIFF_W-1:0]      diff_ff, diff_in;
   logic        [SD_BITS-1:0]     sd_ff, sd_in;
   logic        [DEPTH_BITS-1:0]  dint_ff, dint_in;
   logic        [Q_BITS-1:0]      frac_ff, frac_in;
   logic                          vld_ff, vld_in;
   logic signed [SAMPLE_BITS-1:0] a_ff, a_in;
   logic signed [MUL_A_W-1:0]     dab_ff, dab_in;
   logic signed [SAMPLE_BITS-1:0] r_ff, r_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic        [DEPTH_BITS-1:0]  wp_ff, wp_in;
   logic        [DEPTH_BITS:0]    fill_ff, fill_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   logic                          out_load;
   logic        [DEPTH_BITS-1:0]  k_b;
   logic        [DEPTH_BITS-1:0]  addr_a;
   logic        [DEPTH_BITS-1:0]  addr_b;
   logic                          vld_a;
   logic                          vld_b;
   logic signed [SAMPLE_BITS-1:0] tap;
   logic signed [MUL_A_W-1:0]     mul_a;
   logic signed [MUL_B_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]      prod;
   logic signed [ACC_W-1:0]       shifted;
   logic signed [ACC_W-1:0]       r_sum;
   logic        [DEPTH_BITS-1:0]  dint_raw;

   assign accept   = ctrl.cw.lat_in && ctrl.go;
   assign out_load = ctrl.cw.ld_out && ctrl.go;

   assign req_chan.ready   = ctrl.cw.lat_in && !reset;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.audio_out = out_ff;

   assign status.req_valid = req_chan.valid;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      k_b    = dint_ff + 1'b1;
      addr_a = wp_ff + dint_ff;
      addr_b = wp_ff + k_b;
      vld_a  = (dint_ff != '0) ? ({1'b0, dint_ff} <= fill_ff) : fill_ff[DEPTH_BITS];
      vld_b  = {1'b0, k_b} <= fill_ff;
      tap    = vld_ff ? $signed(ram_rd_data) : '0;

      case (ctrl.cw.mul_a)
         MA_DAB:  mul_a = dab_ff;
         MA_R:    mul_a = MUL_A_W'(r_ff);
         MA_X:    mul_a = MUL_A_W'(x_ff);
         default: mul_a = '0;
      endcase
      case (ctrl.cw.mul_b)
         MB_FRAC: mul_b = $signed(MUL_B_W'(frac_ff));
         MB_FB:   mul_b = $signed(MUL_B_W'(fb_ff));
         MB_MIX:  mul_b = $signed(MUL_B_W'(mix_ff));
         MB_DRY:  mul_b = $signed(MUL_B_W'(Q_ONE) - MUL_B_W'(mix_ff));
         default: mul_b = '0;
      endcase
      prod    = mul_a * mul_b;
      shifted = acc_ff >>> Q_BITS;
      r_sum   = ACC_W'(a_ff) + shifted;

      ram_req.rd_addr = (ctrl.cw.rd_sel == RD_TAP_B) ? addr_b : addr_a;
      ram_req.wr_en   = ctrl.cw.wr_mem;
      ram_req.wr_addr = wp_ff;
      ram_req.wr_data = sat_sample(ACC_W'(x_ff) + shifted);

      x_in   = x_ff;
      tgt_in = tgt_ff;
      fb_in  = fb_ff;
      mix_in = mix_ff;
      byp_in = byp_ff;
      if (accept) begin
         x_in   = req_chan.audio_in;
         fb_in  = req_chan.feedback_gain;
         mix_in = req_chan.mix_level;
         byp_in = req_chan.bypass_on;
         if (req_chan.delay_target == '0) begin
            tgt_in = DEPTH_BITS'(1);
         end else if (32'(req_chan.delay_target) > 32'(DELAY_MAX)) begin
            tgt_in = DEPTH_BITS'(DELAY_MAX);
         end else begin
            tgt_in = DEPTH_BITS'(req_chan.delay_target);
         end
      end

      diff_in = ctrl.cw.ld_diff
              ? $signed({1'b0, tgt_ff, {Q_BITS{1'b0}}}) - $signed({1'b0, sd_ff})
              : diff_ff;

      case (ctrl.cw.acc_op)
         ACC_D13:  acc_in = ACC_W'(diff_ff) * ACC_W'(SMOOTH_COEF);
         ACC_LOAD: acc_in = ACC_W'(prod);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod);
         default:  acc_in = acc_ff;
      endcase

      sd_in = ctrl.cw.ld_sd ? sd_ff + shifted[SD_BITS-1:0] : sd_ff;

      dint_raw = sd_ff[SD_BITS-1:Q_BITS];
      dint_in  = dint_ff;
      frac_in  = frac_ff;
      if (ctrl.cw.ld_df) begin
         if (32'(dint_raw) > 32'(DELAY_MAX)) begin
            dint_in = DEPTH_BITS'(DELAY_MAX);
            frac_in = '0;
         end else begin
            dint_in = dint_raw;
            frac_in = sd_ff[Q_BITS-1:0];
         end
      end

      case (ctrl.cw.rd_sel)
         RD_TAP_A: vld_in = vld_a;
         RD_TAP_B: vld_in = vld_b;
         default:  vld_in = vld_ff;
      endcase

      a_in   = ctrl.cw.ld_a ? tap : a_ff;
      dab_in = ctrl.cw.ld_dab ? MUL_A_W'(tap) - MUL_A_W'(a_ff) : dab_ff;
      r_in   = ctrl.cw.ld_r ? r_sum[SAMPLE_BITS-1:0] : r_ff;

      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (ctrl.cw.wr_mem) begin
         wp_in = wp_ff - 1'b1;
         if (!fill_ff[DEPTH_BITS]) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         out_in       = byp_ff ? x_ff : sat_sample(shifted);
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sd_ff        <= sd_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      tgt_ff  <= tgt_in;
      fb_ff   <= fb_in;
      mix_ff  <= mix_in;
      byp_ff  <= byp_in;
      diff_ff <= diff_in;
      dint_ff <= dint_in;
      frac_ff <= frac_in;
      vld_ff  <= vld_in;
      a_ff    <= a_in;
      dab_ff  <= dab_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

endmodule

// ===== sv/feedback_delay_effect_unit.sv =====
// Feedback delay with a smoothed fractional delay length.
// req_chan carries one sample with its delay target, feedback, mix and
// bypass; rsp_chan returns one output sample per accepted item. Both use
// valid/ready, a transfer taking place when both are high.
// A microcoded sequencer runs a fourteen-step program per item over one
// shared 25x18 multiplier and a delay RAM with one write and one
// registered read port: the result is loaded into the output register at the
// last step, and the next item is taken only once the program has returned
// to its first step.
// The result sits in an output register; the next input is accepted while
// it waits. If the receiver stalls, the program holds at its last step
// until the register is free, and req_chan.ready stays low meanwhile.
// Reset (synchronous, active high) zeroes the write pointer and the
// smoothed delay. The delay RAM is not swept: a fill count marks which
// slots have been written, and unwritten taps read as silence, so the
// block takes items from the first cycle after reset.
module feedback_delay_effect_unit import fde_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fde_req_if.sink   req_chan,
   fde_rsp_if.source rsp_chan
);

   seq_ctrl_type           ctrl;
   dp_status_type          status;
   ram_req_type            ram_req;
   logic [SAMPLE_BITS-1:0] ram_rd_data;

   fde_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   fde_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .status      (status),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   fde_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== dv/feedback_delay_effect_unit_test.sv =====
module feedback_delay_effect_unit_test;
   import fde_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FULL_RATE} idle_phase_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] audio_in;
      logic        [CTRL_BITS-1:0]   delay_target;
      logic        [CTRL_BITS-1:0]   feedback_gain;
      logic        [CTRL_BITS-1:0]   mix_level;
      logic                          bypass_on;
      idle_phase_type                phase;
   } echo_sample_type;

   localparam int RANDOM_PER_PHASE = 600;
   localparam int DRAIN_CYCLES     = 40;

   int sender_idle_pct   [3] = '{12, 82, 0};
   int receiver_idle_pct [3] = '{82, 12, 0};

   logic clock;
   logic reset;

   fde_req_if req_chan ();
   fde_rsp_if rsp_chan ();

   feedback_delay_effect_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   echo_sample_type               pending_samples [$];
   logic signed [SAMPLE_BITS-1:0] expected_audio  [$];
   idle_phase_type                active_phase;

   logic signed [SAMPLE_BITS-1:0] echo_mem [DELAY_DEPTH];
   int                            echo_wr_ptr;
   longint                        smooth_len;

   int error_count;
   int taken_count;
   int checked_count;
   int bypass_count;
   int clamped_count;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         v = hi;
      end else if (v < lo) begin
         v = lo;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] predict_echo_output(
      input echo_sample_type s);
      longint x;
      longint tgt;
      longint diff;
      longint dint;
      longint frac;
      longint a;
      longint b;
      longint r;
      int     ia;
      int     ib;
      x   = longint'(s.audio_in);
      tgt = longint'(s.delay_target);
      if (tgt < 1) begin
         tgt = 1;
      end
      if (tgt > DELAY_MAX) begin
         tgt = DELAY_MAX;
      end
      diff       = (tgt <<< Q_BITS) - smooth_len;
      smooth_len = smooth_len + ((diff * SMOOTH_COEF) >>> Q_BITS);
      smooth_len = smooth_len & ((longint'(1) <<< SD_BITS) - 1);
      dint = smooth_len >>> Q_BITS;
      frac = smooth_len & (Q_ONE - 1);
      if (dint > DELAY_MAX) begin
         dint = DELAY_MAX;
         frac = 0;
      end
      ia = int'((longint'(echo_wr_ptr) + dint) % DELAY_DEPTH);
      ib = (ia + 1) % DELAY_DEPTH;
      a  = longint'(echo_mem[ia]);
      b  = longint'(echo_mem[ib]);
      r  = a + (((b - a) * frac) >>> Q_BITS);
      echo_mem[echo_wr_ptr] =
         clip_sample(x + ((longint'(s.feedback_gain) * r) >>> Q_BITS));
      echo_wr_ptr = (echo_wr_ptr + DELAY_DEPTH - 1) % DELAY_DEPTH;
      if (s.bypass_on) begin
         return s.audio_in;
      end
      return clip_sample((longint'(s.mix_level) * r +
                          (Q_ONE - longint'(s.mix_level)) * x) >>> Q_BITS);
   endfunction

   task automatic queue_sample(input int audio, input int target, input int fb,
                               input int mix, input bit byp, input idle_phase_type ph);
      echo_sample_type s;
      s.audio_in      = audio[SAMPLE_BITS-1:0];
      s.delay_target  = target[CTRL_BITS-1:0];
      s.feedback_gain = fb[CTRL_BITS-1:0];
      s.mix_level     = mix[CTRL_BITS-1:0];
      s.bypass_on     = byp;
      s.phase         = ph;
      pending_samples.push_back(s);
   endtask

   function automatic int pick_gain();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) begin
         return $urandom_range(Q_ONE, 0);
      end else if (sel < 80) begin
         return Q_ONE;
      end else if (sel < 85) begin
         return 0;
      end
      return $urandom_range((1 << CTRL_BITS) - 1, 0);
   endfunction

   function automatic int pick_target();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) begin
         return $urandom_range(48, 1);
      end else if (sel < 85) begin
         return $urandom_range((1 << CTRL_BITS) - 1, 0);
      end else if (sel < 92) begin
         return $urandom_range((1 << CTRL_BITS) - 1, DELAY_MAX - 2);
      end
      return $urandom_range(2, 0);
   endfunction

   function automatic int pick_audio();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) begin
         return (1 << (SAMPLE_BITS - 1)) - 1;
      end else if (sel < 16) begin
         return -(1 << (SAMPLE_BITS - 1));
      end
      return int'($urandom());
   endfunction

   initial begin
      int max_s;
      int min_s;
      reset = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.audio_in      = '0;
      req_chan.delay_target  = '0;
      req_chan.feedback_gain = '0;
      req_chan.mix_level     = '0;
      req_chan.bypass_on     = 1'b0;
      rsp_chan.ready         = 1'b0;
      active_phase  = PH_SLOW_SINK;
      echo_wr_ptr   = 0;
      smooth_len    = 0;
      error_count   = 0;
      taken_count   = 0;
      checked_count = 0;
      bypass_count  = 0;
      clamped_count = 0;
      foreach (echo_mem[i]) begin
         echo_mem[i] = '0;
      end
      max_s = (1 << (SAMPLE_BITS - 1)) - 1;
      min_s = -(1 << (SAMPLE_BITS - 1));

      queue_sample(0, 0, 0, 0, 1'b0, PH_SLOW_SINK);
      queue_sample(max_s, 1, Q_ONE, Q_ONE, 1'b0, PH_SLOW_SINK);
      queue_sample(min_s, 1, Q_ONE, 0, 1'b0, PH_SLOW_SINK);
      queue_sample(1234567, 5, Q_ONE / 2, Q_ONE / 2, 1'b1, PH_SLOW_SINK);
      queue_sample(-1, 3, Q_ONE, 131071, 1'b1, PH_SLOW_SINK);
      repeat (5) begin
         queue_sample(max_s, 1, 131071, Q_ONE, 1'b0, PH_SLOW_SINK);
      end
      repeat (3) begin
         queue_sample(min_s, 2, 131071, 131071, 1'b0, PH_SLOW_SINK);
      end
      queue_sample(max_s, DELAY_MAX, Q_ONE, Q_ONE, 1'b0, PH_SLOW_SINK);
      queue_sample(min_s, DELAY_MAX + 1, 131071, 131071, 1'b0, PH_SLOW_SINK);
      queue_sample(max_s, 131071, Q_ONE, 0, 1'b0, PH_SLOW_SINK);
      queue_sample(min_s, 131071, 0, 131071, 1'b0, PH_SLOW_SINK);
      queue_sample(4096, 64, Q_ONE, Q_ONE / 4, 1'b0, PH_SLOW_SINK);
      queue_sample(-4096, 0, Q_ONE / 2, Q_ONE, 1'b1, PH_SLOW_SINK);
      queue_sample(max_s, DELAY_MAX, 131071, 131071, 1'b1, PH_SLOW_SINK);

      for (int ph = 0; ph < 3; ph++) begin
         repeat (RANDOM_PER_PHASE) begin
            queue_sample(pick_audio(), pick_target(), pick_gain(), pick_gain(),
                         ($urandom_range(99) < 20), idle_phase_type'(ph));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_samples.size() != 0 || req_chan.valid || expected_audio.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d input transfers and %0d checked outputs over three idling phases",
               taken_count, checked_count);
      $display("  %0d bypassed samples, %0d with the delay target clamped",
               bypass_count, clamped_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_samples.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct[int'(pending_samples[0].phase)]) begin
            req_chan.audio_in      <= pending_samples[0].audio_in;
            req_chan.delay_target  <= pending_samples[0].delay_target;
            req_chan.feedback_gain <= pending_samples[0].feedback_gain;
            req_chan.mix_level     <= pending_samples[0].mix_level;
            req_chan.bypass_on     <= pending_samples[0].bypass_on;
            active_phase           <= pending_samples[0].phase;
            req_chan.valid         <= 1'b1;
            void'(pending_samples.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      echo_sample_type               s;
      logic signed [SAMPLE_BITS-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct[int'(active_phase)]);
         if (req_chan.valid && req_chan.ready) begin
            s.audio_in      = req_chan.audio_in;
            s.delay_target  = req_chan.delay_target;
            s.feedback_gain = req_chan.feedback_gain;
            s.mix_level     = req_chan.mix_level;
            s.bypass_on     = req_chan.bypass_on;
            s.phase         = active_phase;
            expected_audio.push_back(predict_echo_output(s));
            taken_count++;
            if (s.bypass_on) begin
               bypass_count++;
            end
            if (s.delay_target < 1 || s.delay_target > DELAY_MAX) begin
               clamped_count++;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_audio.size() == 0) begin
               $error("audio_out transfer with nothing expected: actual %0d",
                      rsp_chan.audio_out);
               error_count++;
            end else begin
               want = expected_audio.pop_front();
               checked_count++;
               if (rsp_chan.audio_out !== want) begin
                  $error("audio_out mismatch: expected %0d, actual %0d",
                         want, rsp_chan.audio_out);
                  error_count++;
               end
            end
         end
      end
   end

endmodule
